// File: design/smtc_pkg.sv
// Package for the sequence-to-MIDI track converter: the sequencer phase type, the byte
// codes, the error codes and the burst word handed from the step logic to the serializer.
// It depends on nothing. Every other file in the design refers to it by scoped name.
package smtc_pkg;

  localparam int MaxRes = 7;

  typedef enum logic [2:0] {
    PH_DELTA       = 3'd0,
    PH_CODE        = 3'd1,
    PH_DATA1       = 3'd2,
    PH_DATA2       = 3'd3,
    PH_EOT_PENDING = 3'd4,
    PH_HALTED      = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_CHANNEL   = 3'd1,
    ERR_NO_STATUS = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_DELTA_OVF = 3'd4
  } err_t;

  localparam logic [7:0] DeltaPrefix  = 8'hF8;
  localparam logic [7:0] DeltaStep    = 8'd240;
  localparam logic [7:0] SeqEnd       = 8'hFC;
  localparam logic [3:0] HiNoteOn     = 4'h9;
  localparam logic [3:0] HiNoteOff    = 4'h8;
  localparam logic [3:0] HiControl    = 4'hB;
  localparam logic [3:0] HiProgram    = 4'hC;
  localparam logic [3:0] HiPitch      = 4'hE;
  localparam logic [7:0] MetaEvent    = 8'hFF;
  localparam logic [7:0] MetaEndTrack = 8'h2F;

  // One event's worth of track bytes, loaded into the serializer as a whole.
  typedef struct packed {
    logic             load;
    logic [2:0]       cnt;
    logic [6:0][7:0]  bytes;
    err_t             err;
    logic             done;
  } burst_t;

endpackage

// File: design/sequence_to_midi_track_converter_top.sv
// Top level of the sequence-to-MIDI track converter: channel register, step logic and
// burst serializer. Depends on smtc_pkg, smtc_core and smtc_burst.
//
// Usage:
//   The slave stream carries one byte of the compact sequence per word (tdata) with
//   tlast marking the last byte of the stream. The master stream carries one Standard
//   MIDI File track byte per word; tlast marks the last word caused by one input word,
//   tuser[2:0] carries the error code (nonzero only on a lone error word, data 0) and
//   tuser[3] flags the final end-of-track byte.
//   cfg_we/cfg_data write the MIDI channel; write it only while the block is idle.
// Path: input register, then burst register, then the first track byte of the event.
// Throughput: with the serializer free and tready high, the block takes one input word
//   per cycle while each word causes at most one track byte; a word that causes more (up
//   to seven) drains them one per cycle, set by the single output port of the burst
//   serializer. The input register takes one more word while a burst drains on the master side.
// Reset: channel returns to 15, the sequencer expects a delta byte with no running
//   status, and both streams go empty.
// Stall: when the receiver holds tready low the burst holds, the input register fills,
//   and then tready on the slave side drops until the burst drains.
// After end of track or an error the block swallows further input without output.
module sequence_to_midi_track_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic [3:0]  m_axis_tuser    // [2:0] error_code, [3] track_done
);

  logic [3:0]        channel;
  smtc_pkg::burst_t  burst;
  logic              burst_ready;

  // Hold the configured channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= 4'd15;
    end else if (cfg_we) begin
      channel <= cfg_data;
    end
  end

  // Decode one byte per cycle, while the serializer accepts bursts, into a burst of track bytes.
  smtc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .channel     (channel),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .in_eos      (s_axis_tlast),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  // Drain the burst one word per cycle while the receiver is ready.
  smtc_burst u_burst (
    .clk           (clk),
    .rst           (rst),
    .burst         (burst),
    .burst_ready   (burst_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: design/smtc_core.sv
// Step logic of the sequence-to-MIDI track converter: input word register, sequencer
// state and the single-pass decode that turns one stream byte into a burst of track bytes.
// Depends on smtc_pkg.
module smtc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        channel,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_eos,
  input  logic              burst_ready,
  output smtc_pkg::burst_t  burst
);

  logic                 in_vld;
  logic [7:0]           in_b;
  logic                 in_e;
  logic                 fire;

  smtc_pkg::phase_t     phase, phase_next;
  logic [27:0]          acc, acc_next;
  logic [7:0]           rs, rs_next;
  logic [7:0]           fdb, fdb_next;

  logic                 ph_delta, ph_code, ph_data1, ph_data2, ph_pend, core_ph;
  logic                 is_status, is_fc, is_f8, rs_is_c, run_code, finished;
  logic [7:0]           add;
  logic [28:0]          sum;
  logic                 e1, e2, e3, e4, any_err, use_delta, fits, eot, pend;
  smtc_pkg::err_t       err;
  logic [2:0]           dn, en, o1, o2;
  logic [3:0][6:0]      grp;
  logic [3:0][7:0]      db, ev, eb;
  logic [7:0]           st;

  assign fire     = in_vld && burst_ready;
  assign in_ready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_b <= in_byte;
      in_e <= in_eos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= smtc_pkg::PH_DELTA;
      acc   <= '0;
      rs    <= '0;
      fdb   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      acc   <= acc_next;
      rs    <= rs_next;
      fdb   <= fdb_next;
    end
  end

  // Shared decode
  assign ph_delta = phase == smtc_pkg::PH_DELTA;
  assign ph_code  = phase == smtc_pkg::PH_CODE;
  assign ph_data1 = phase == smtc_pkg::PH_DATA1;
  assign ph_data2 = phase == smtc_pkg::PH_DATA2;
  assign ph_pend  = phase == smtc_pkg::PH_EOT_PENDING;
  assign core_ph  = ph_delta || ph_code || ph_data1 || ph_data2;

  assign is_status = (in_b[7:4] == smtc_pkg::HiNoteOn) || (in_b[7:4] == smtc_pkg::HiControl) ||
                     (in_b[7:4] == smtc_pkg::HiProgram) || (in_b[7:4] == smtc_pkg::HiPitch);
  assign is_fc     = in_b == smtc_pkg::SeqEnd;
  assign is_f8     = in_b == smtc_pkg::DeltaPrefix;
  assign rs_is_c   = rs[7:4] == smtc_pkg::HiProgram;

  assign add = is_f8 ? smtc_pkg::DeltaStep : in_b;
  assign sum = {1'b0, acc} + {21'b0, add};

  assign run_code = ph_code && !is_status && !is_fc && (rs != 8'd0);
  assign finished = ((run_code || ph_data1) && rs_is_c) || ph_data2;

  assign e4 = ph_delta && sum[28];
  assign e1 = ph_code && is_status && (in_b[3:0] != channel);
  assign e2 = ph_code && !is_status && !is_fc && (rs == 8'd0);
  assign e3 = core_ph && in_e && !finished && !(ph_code && is_fc) && !e4 && !e1 && !e2;

  always_comb begin
    if (e4) begin
      err = smtc_pkg::ERR_DELTA_OVF;
    end else if (e1) begin
      err = smtc_pkg::ERR_CHANNEL;
    end else if (e2) begin
      err = smtc_pkg::ERR_NO_STATUS;
    end else if (e3) begin
      err = smtc_pkg::ERR_TRUNCATED;
    end else begin
      err = smtc_pkg::ERR_NONE;
    end
  end
  assign any_err = err != smtc_pkg::ERR_NONE;

  // Variable-length delta: 7-bit groups, most significant first
  always_comb begin
    if (acc[27:21] != 7'd0) begin
      dn = 3'd4;
    end else if (acc[20:14] != 7'd0) begin
      dn = 3'd3;
    end else if (acc[13:7] != 7'd0) begin
      dn = 3'd2;
    end else begin
      dn = 3'd1;
    end
  end

  always_comb begin
    logic [2:0] gi;
    for (int j = 0; j < 4; j++) begin
      grp[j] = acc[7*j +: 7];
    end
    for (int j = 0; j < 4; j++) begin
      gi    = dn - 3'd1 - 3'(j);
      db[j] = {(3'(j) < (dn - 3'd1)), grp[gi[1:0]]};
    end
  end

  assign use_delta = (ph_code && is_status && !e1) || run_code;
  always_comb begin
    if (ph_data2) begin
      en = 3'd3;
    end else if ((run_code || ph_data1) && rs_is_c) begin
      en = 3'd2;
    end else begin
      en = 3'd0;
    end
  end
  assign o1   = use_delta ? dn : 3'd0;
  assign o2   = o1 + en;
  assign fits = o2 <= 3'd3;

  // Note-on with zero velocity goes out as note-off
  assign st = ((rs[7:4] == smtc_pkg::HiNoteOn) && (in_b == 8'd0)) ?
              {smtc_pkg::HiNoteOff, channel} : rs;
  assign ev[0] = ph_data2 ? st : rs;
  assign ev[1] = ph_data2 ? fdb : in_b;
  assign ev[2] = in_b;
  assign ev[3] = 8'd0;
  assign eb[0] = 8'd0;
  assign eb[1] = smtc_pkg::MetaEvent;
  assign eb[2] = smtc_pkg::MetaEndTrack;
  assign eb[3] = 8'd0;

  assign eot  = !any_err && ((ph_code && is_fc) || ph_pend || (in_e && finished && fits));
  assign pend = !any_err && in_e && finished && !fits;

  // Next state
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    rs_next    = rs;
    fdb_next   = fdb;
    unique case (phase)
      smtc_pkg::PH_DELTA: begin
        acc_next = sum[27:0];
        if (!is_f8) begin
          phase_next = smtc_pkg::PH_CODE;
        end
      end
      smtc_pkg::PH_CODE: begin
        if (is_status) begin
          rs_next    = in_b;
          acc_next   = '0;
          phase_next = smtc_pkg::PH_DATA1;
        end else if (!is_fc) begin
          acc_next   = '0;
          fdb_next   = in_b;
          phase_next = rs_is_c ? smtc_pkg::PH_DELTA : smtc_pkg::PH_DATA2;
        end
      end
      smtc_pkg::PH_DATA1: begin
        fdb_next   = in_b;
        phase_next = rs_is_c ? smtc_pkg::PH_DELTA : smtc_pkg::PH_DATA2;
      end
      smtc_pkg::PH_DATA2: begin
        phase_next = smtc_pkg::PH_DELTA;
      end
      smtc_pkg::PH_EOT_PENDING: begin
        phase_next = smtc_pkg::PH_HALTED;
      end
      default: begin
        phase_next = smtc_pkg::PH_HALTED;
      end
    endcase
    if (any_err || eot) begin
      phase_next = smtc_pkg::PH_HALTED;
    end else if (pend) begin
      phase_next = smtc_pkg::PH_EOT_PENDING;
    end
  end

  // Burst assembly: delta bytes, then event bytes, then end-of-track bytes; an error gives one zero byte
  always_comb begin
    logic [2:0] r1, r2;
    burst.err  = err;
    burst.done = eot;
    burst.cnt  = any_err ? 3'd1 : (o2 + (eot ? 3'd4 : 3'd0));
    burst.load = fire && (burst.cnt != 3'd0);
    for (int k = 0; k < smtc_pkg::MaxRes; k++) begin
      r1 = 3'(k) - o1;
      r2 = 3'(k) - o2;
      if (any_err) begin
        burst.bytes[k] = 8'd0;
      end else if (3'(k) < o1) begin
        burst.bytes[k] = db[k % 4];
      end else if (3'(k) < o2) begin
        burst.bytes[k] = ev[r1[1:0]];
      end else begin
        burst.bytes[k] = eb[r2[1:0]];
      end
    end
  end

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    phase == smtc_pkg::PH_HALTED |-> !burst.load)
    else $error("halted sequencer produced a burst");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    burst.load && burst.err != smtc_pkg::ERR_NONE |=> phase == smtc_pkg::PH_HALTED)
    else $error("error burst did not halt the sequencer");

endmodule

// File: design/smtc_burst.sv
// Burst serializer of the sequence-to-MIDI track converter: holds up to seven track bytes
// and presents them one word per cycle on the master stream while the receiver is ready.
// Depends on smtc_pkg.
module smtc_burst (
  input  logic              clk,
  input  logic              rst,
  input  smtc_pkg::burst_t  burst,
  output logic              burst_ready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,
  output logic              m_axis_tlast,
  output logic [3:0]        m_axis_tuser
);

  logic              busy;
  logic [2:0]        idx;
  logic [2:0]        cnt;
  logic [6:0][7:0]   bytes;
  smtc_pkg::err_t    err;
  logic              done;
  logic              last;
  logic              pop;

  assign last        = idx == (cnt - 3'd1);
  assign pop         = busy && m_axis_tready;
  assign burst_ready = !busy || (pop && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (burst.load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (pop) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load) begin
      cnt   <= burst.cnt;
      bytes <= burst.bytes;
      err   <= burst.err;
      done  <= burst.done;
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = bytes[idx];
  assign m_axis_tlast  = last;
  assign m_axis_tuser  = {done && last, err};

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 3'd0)
    else $error("serializer busy with an empty burst");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    busy && err != smtc_pkg::ERR_NONE |-> cnt == 3'd1 && !done)
    else $error("error burst longer than one word");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    busy && !(m_axis_tready && last) |-> !burst.load)
    else $error("burst loaded over undelivered words");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for sequence_to_midi_track_converter_top: drives byte streams,
// predicts the MIDI track words and compares them. Depends on smtc_pkg and the design top.
module testbench;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseWords   = 30;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned HaltWords    = 12;
  localparam int unsigned HaltWordsLong = 220;
  // Prefix count for a three-group delta.
  localparam int unsigned ThreeGroupPrefixes = 70;
  localparam logic [31:0] DeltaMax          = 32'h0FFF_FFFF;

  // How the stream ends; the block halts afterwards, so one run reaches one ending.
  typedef enum logic [2:0] {
    END_SEQ_END,
    END_EOS_SHORT,
    END_EOS_LONG,
    END_TRUNCATED,
    END_CHANNEL,
    END_NO_STATUS
  } ending_t;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic [2:0] code;
    logic       track_end;
  } track_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;   // end_of_stream
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic       m_axis_tlast;          // last_of_run
  logic [3:0] m_axis_tuser;          // [2:0] error_code, [3] track_done

  sequence_to_midi_track_converter_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  int unsigned src_idle   = 0;
  int unsigned sink_stall = 0;
  int unsigned words_sent = 0;
  int unsigned fail_count = 0;

  // Encoder state as the testbench sees it.
  smtc_pkg::phase_t seq_phase = smtc_pkg::PH_DELTA;
  logic [31:0] delta_acc   = 32'd0;
  logic [7:0]  run_status  = 8'd0;
  logic [7:0]  first_data  = 8'd0;
  logic [3:0]  chan        = 4'd15;

  track_word_t step_words[$];
  track_word_t expected_track_bytes[$];

  task automatic flag_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- prediction

  function automatic logic is_voice_status(input logic [7:0] b);
    return b[7:4] == smtc_pkg::HiNoteOn || b[7:4] == smtc_pkg::HiControl ||
           b[7:4] == smtc_pkg::HiProgram || b[7:4] == smtc_pkg::HiPitch;
  endfunction

  function automatic void put_track_byte(input logic [7:0] b, input logic done);
    track_word_t w;
    w.value     = b;
    w.run_end   = 1'b0;
    w.code      = smtc_pkg::ERR_NONE;
    w.track_end = done;
    step_words.push_back(w);
  endfunction

  // Variable-length delta: 7-bit groups, most significant first, continuation bit set.
  function automatic void put_delta(input logic [31:0] d);
    logic [6:0] groups [4];
    int n;
    n = 0;
    do begin
      groups[n] = d[6:0];
      n++;
      d = d >> 7;
    end while (d != 0 && n < 4);
    for (int i = n - 1; i >= 0; i--) put_track_byte({i > 0, groups[i]}, 1'b0);
  endfunction

  function automatic void put_end_of_track();
    put_track_byte(8'h00, 1'b0);
    put_track_byte(smtc_pkg::MetaEvent, 1'b0);
    put_track_byte(smtc_pkg::MetaEndTrack, 1'b0);
    put_track_byte(8'h00, 1'b1);
    seq_phase = smtc_pkg::PH_HALTED;
  endfunction

  function automatic void put_error(input smtc_pkg::err_t code);
    track_word_t w;
    step_words.delete();
    w.value     = 8'h00;
    w.run_end   = 1'b0;
    w.code      = code;
    w.track_end = 1'b0;
    step_words.push_back(w);
    seq_phase = smtc_pkg::PH_HALTED;
  endfunction

  // First data byte: a program change finishes here, the other kinds wait for one more.
  function automatic logic take_first_data(input logic [7:0] b);
    first_data = b;
    if (run_status[7:4] == smtc_pkg::HiProgram) begin
      put_track_byte(run_status, 1'b0);
      put_track_byte(b, 1'b0);
      seq_phase = smtc_pkg::PH_DELTA;
      return 1'b1;
    end
    seq_phase = smtc_pkg::PH_DATA2;
    return 1'b0;
  endfunction

  // Advance the encoder by one stream byte and queue the track words it causes.
  function automatic void encode_byte(input logic [7:0] b, input logic eos);
    logic        finished;
    logic        stop;
    logic [31:0] add;
    logic [7:0]  st;
    finished = 1'b0;
    stop     = 1'b0;
    step_words.delete();
    if (seq_phase == smtc_pkg::PH_EOT_PENDING) begin
      put_end_of_track();
    end else if (seq_phase != smtc_pkg::PH_HALTED) begin
      case (seq_phase)
        smtc_pkg::PH_DELTA: begin
          add = (b == smtc_pkg::DeltaPrefix) ? 32'(smtc_pkg::DeltaStep) : 32'(b);
          if (delta_acc + add > DeltaMax) begin
            put_error(smtc_pkg::ERR_DELTA_OVF);
            stop = 1'b1;
          end else begin
            delta_acc = delta_acc + add;
            if (b != smtc_pkg::DeltaPrefix) seq_phase = smtc_pkg::PH_CODE;
          end
        end
        smtc_pkg::PH_CODE: begin
          if (is_voice_status(b)) begin
            if (b[3:0] != chan) begin
              put_error(smtc_pkg::ERR_CHANNEL);
              stop = 1'b1;
            end else begin
              run_status = b;
              put_delta(delta_acc);
              delta_acc = 32'd0;
              seq_phase = smtc_pkg::PH_DATA1;
            end
          end else if (b == smtc_pkg::SeqEnd) begin
            // end of sequence closes the track whatever tlast says
            put_end_of_track();
            stop = 1'b1;
          end else if (run_status == 8'd0) begin
            put_error(smtc_pkg::ERR_NO_STATUS);
            stop = 1'b1;
          end else begin
            put_delta(delta_acc);
            delta_acc = 32'd0;
            finished  = take_first_data(b);
          end
        end
        smtc_pkg::PH_DATA1: finished = take_first_data(b);
        default: begin
          st = run_status;
          // note-on with velocity zero goes out as note-off on the current channel
          if (st[7:4] == smtc_pkg::HiNoteOn && b == 8'd0) st = {smtc_pkg::HiNoteOff, chan};
          put_track_byte(st, 1'b0);
          put_track_byte(first_data, 1'b0);
          put_track_byte(b, 1'b0);
          finished  = 1'b1;
          seq_phase = smtc_pkg::PH_DELTA;
        end
      endcase
      if (eos && !stop) begin
        if (!finished) put_error(smtc_pkg::ERR_TRUNCATED);
        else if (step_words.size() + 4 <= smtc_pkg::MaxRes) put_end_of_track();
        else seq_phase = smtc_pkg::PH_EOT_PENDING;   // end-of-track rides on the next word
      end
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].run_end = 1'b1;
    foreach (step_words[i]) expected_track_bytes.push_back(step_words[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Send one stream byte: idle at random, hold until the handshake, then predict.
  task automatic send_word(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
    encode_byte(b, eos);
  endtask

  // Hold the sender until every expected word has come out.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_track_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic set_channel(input logic [3:0] v);
    wait_drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    chan = v;
  endtask

  function automatic logic [3:0] pick_kind();
    case ($urandom_range(0, 3))
      0:       return smtc_pkg::HiNoteOn;
      1:       return smtc_pkg::HiControl;
      2:       return smtc_pkg::HiProgram;
      default: return smtc_pkg::HiPitch;
    endcase
  endfunction

  function automatic logic [7:0] pick_delta_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == smtc_pkg::DeltaPrefix);
    return b;
  endfunction

  // Code byte that falls back on the running status.
  function automatic logic [7:0] pick_reuse_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_voice_status(b) || b == smtc_pkg::SeqEnd);
    return b;
  endfunction

  task automatic send_prefixes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(smtc_pkg::DeltaPrefix, 1'b0);
  endtask

  // One complete event; eos marks its last byte.
  task automatic send_event(input int unsigned prefixes, input logic [7:0] delta_byte,
                            input logic [3:0] kind, input logic reuse, input logic eos);
    logic       two_data;
    logic [7:0] d1;
    logic [7:0] d2;
    send_prefixes(prefixes);
    send_word(delta_byte, 1'b0);
    d2 = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    if (reuse) begin
      two_data = run_status[7:4] != smtc_pkg::HiProgram;
      d1 = pick_reuse_byte();
    end else begin
      two_data = kind != smtc_pkg::HiProgram;
      d1 = 8'($urandom_range(0, 255));
      send_word({kind, chan}, 1'b0);
    end
    send_word(d1, eos && !two_data);
    if (two_data) send_word(d2, eos);
  endtask

  task automatic send_random_event();
    int unsigned r;
    int unsigned prefixes;
    r = $urandom_range(0, 39);
    if (r == 0) prefixes = $urandom_range(4, 6);
    else if (r < 8) prefixes = $urandom_range(1, 3);
    else prefixes = 0;
    send_event(prefixes, pick_delta_byte(), pick_kind(),
               run_status != 8'd0 && $urandom_range(0, 1) == 1, 1'b0);
  endtask

  // ---------------------------------------------------------------- tests

  // Every event kind on the reset channel, delta group edges, running status,
  // velocity zero, data bytes with bit 7 set and the end code used as a delta byte.
  task automatic test_directed();
    src_idle   = 27;
    sink_stall = 27;
    send_word(8'h00, 1'b0);
    send_word({smtc_pkg::HiNoteOn, chan}, 1'b0);
    send_word(8'h3C, 1'b0);
    send_word(8'h64, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h3C, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(smtc_pkg::DeltaPrefix, 1'b0);
    send_word(8'h08, 1'b0);
    send_word({smtc_pkg::HiControl, chan}, 1'b0);
    send_word(8'h07, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h80, 1'b0);
    send_word({smtc_pkg::HiProgram, chan}, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h00, 1'b0);
    send_word({smtc_pkg::HiPitch, chan}, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(smtc_pkg::SeqEnd, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'h12, 1'b0);
  endtask

  // Three-group delta, sent without idling to keep the run short.
  task automatic test_long_delta();
    src_idle   = 0;
    sink_stall = 0;
    set_channel(4'($urandom_range(0, 15)));
    send_event(ThreeGroupPrefixes, pick_delta_byte(), pick_kind(), 1'b0, 1'b0);
  endtask

  // Random well-formed events under four idling mixes, new channel per mix,
  // with one pause until the output has drained in the middle of each.
  task automatic test_random();
    int unsigned start;
    logic        paused;
    logic [3:0]  next_chan;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_idle = 0;  sink_stall = 0;  next_chan = 4'($urandom_range(1, 14));
        end
        1: begin
          src_idle = 76; sink_stall = 0;  next_chan = 4'd0;
        end
        2: begin
          src_idle = 0;  sink_stall = 76; next_chan = 4'd15;
        end
        default: begin
          src_idle = 27; sink_stall = 27; next_chan = 4'($urandom_range(0, 15));
        end
      endcase
      set_channel(next_chan);
      start  = words_sent;
      paused = 1'b0;
      while (words_sent - start < PhaseWords) begin
        if (!paused && words_sent - start >= PhaseWords / 2) begin
          wait_drain();
          paused = 1'b1;
        end
        send_random_event();
      end
    end
  endtask

  // Close the stream in one of the ways that halt the block.
  task automatic test_ending(input ending_t ending);
    logic [3:0] kind;
    src_idle   = 27;
    sink_stall = 27;
    kind       = pick_kind();
    case (ending)
      END_SEQ_END: begin
        send_prefixes($urandom_range(0, 2));
        send_word(pick_delta_byte(), 1'b0);
        send_word(smtc_pkg::SeqEnd, 1'($urandom_range(0, 1)));
      end
      END_EOS_SHORT: begin
        // program change with a one-byte delta: event and end-of-track fit one run
        send_event(0, 8'($urandom_range(0, 127)), smtc_pkg::HiProgram, 1'b0, 1'b1);
      end
      END_EOS_LONG: begin
        send_event(0, 8'($urandom_range(0, 127)), smtc_pkg::HiProgram, 1'b0, 1'b0);
        // running program change with a two-group delta overflows one run
        send_event($urandom_range(0, 2), 8'($urandom_range(128, 247)),
                   smtc_pkg::HiProgram, 1'b1, 1'b1);
        // end-of-track comes out on the next word, whose byte is dropped
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      END_TRUNCATED: begin
        case ($urandom_range(0, 2))
          0: send_word(8'($urandom_range(0, 255)), 1'b1);
          1: begin
            send_word(pick_delta_byte(), 1'b0);
            send_word({kind, chan}, 1'b1);
          end
          default: begin
            send_word(pick_delta_byte(), 1'b0);
            send_word({smtc_pkg::HiControl, chan}, 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1);
          end
        endcase
      end
      END_CHANNEL: begin
        send_word(pick_delta_byte(), 1'b0);
        send_word({kind, chan ^ 4'($urandom_range(1, 15))}, 1'($urandom_range(0, 1)));
      end
      default: ;
    endcase
  endtask

  // Data byte before any status: the very first event fails.
  task automatic test_no_status();
    set_channel(4'd0);
    set_channel(4'd15);
    set_channel(4'($urandom_range(0, 15)));
    src_idle   = 27;
    sink_stall = 27;
    send_prefixes($urandom_range(0, 2));
    send_word(pick_delta_byte(), 1'b0);
    send_word(pick_reuse_byte(), 1'($urandom_range(0, 1)));
  endtask

  // A halted block swallows everything.
  task automatic test_after_halt(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    track_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_track_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected word data=%h last=%b user=%h",
                                m_axis_tdata, m_axis_tlast, m_axis_tuser));
      end else begin
        want = expected_track_bytes.pop_front();
        if (m_axis_tdata !== want.value)
          flag_mismatch($sformatf("out_byte %h, expected %h", m_axis_tdata, want.value));
        if (m_axis_tlast !== want.run_end)
          flag_mismatch($sformatf("last_of_run %b, expected %b", m_axis_tlast, want.run_end));
        if (m_axis_tuser[2:0] !== want.code)
          flag_mismatch($sformatf("error_code %0d, expected %0d",
                                  m_axis_tuser[2:0], want.code));
        if (m_axis_tuser[3] !== want.track_end)
          flag_mismatch($sformatf("track_done %b, expected %b",
                                  m_axis_tuser[3], want.track_end));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    ending_t     ending;
    track_word_t left;
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 4) ending = END_SEQ_END;
    else if (r < 7) ending = END_EOS_SHORT;
    else if (r < 10) ending = END_EOS_LONG;
    else if (r < 13) ending = END_TRUNCATED;
    else if (r < 15) ending = END_CHANNEL;
    else ending = END_NO_STATUS;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    if (ending == END_NO_STATUS) begin
      test_no_status();
      test_after_halt(HaltWordsLong);
    end else begin
      test_directed();
      test_long_delta();
      test_random();
      test_ending(ending);
      test_after_halt(HaltWords);
    end

    // Drain with a bound, then let the pipeline settle before the verdict.
    s_axis_tvalid <= 1'b0;
    for (int unsigned n = 0; n < DrainLimit && expected_track_bytes.size() != 0; n++)
      @(posedge clk);
    repeat (SettleCycles * 4) @(posedge clk);
    while (expected_track_bytes.size() != 0) begin
      left = expected_track_bytes.pop_front();
      flag_mismatch($sformatf("missing word data=%h code=%0d", left.value, left.code));
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: a full run with the heaviest stalls needs only a small fraction of this.
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
